// ----- src/reorder_buffer_commit_macros.svh -----
// Assertion helpers for the reorder buffer.
`ifndef REORDER_BUFFER_COMMIT_MACROS_SVH
`define REORDER_BUFFER_COMMIT_MACROS_SVH
// Property checked on every clock edge outside of reset.
`define ROB_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Property checked on every clock edge, reset included.
`define ROB_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`endif

// ----- src/rob_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rob_pkg
// Shared types and constants of the reorder buffer.
// ----------------------------------------------------------------------------
package rob_pkg;
  localparam int DEPTH = 16;
  localparam int SLOT_W = $clog2(DEPTH);
  localparam int OCC_W = $clog2(DEPTH + 1);
  localparam int MAX_RESULTS = 16;
  localparam int CNT_W = $clog2(MAX_RESULTS + 1);

  localparam logic [1:0] MODE_ALLOC = 2'd0;
  localparam logic [1:0] MODE_UPDATE = 2'd1;
  localparam logic [1:0] MODE_TICK = 2'd2;
  localparam logic [1:0] MODE_NONE = 2'd3;

  localparam logic [1:0] CLASS_ORD = 2'd0;
  localparam logic [1:0] CLASS_STORE = 2'd1;
  localparam logic [1:0] CLASS_HALT = 2'd2;
  localparam logic [1:0] CLASS_SPARE = 2'd3;

  localparam logic [2:0] KIND_ALLOC = 3'd0;
  localparam logic [2:0] KIND_FULL = 3'd1;
  localparam logic [2:0] KIND_MATCH = 3'd2;
  localparam logic [2:0] KIND_NOMATCH = 3'd3;
  localparam logic [2:0] KIND_NONE = 3'd4;
  localparam logic [2:0] KIND_REG = 3'd5;
  localparam logic [2:0] KIND_STORE = 3'd6;
  localparam logic [2:0] KIND_HALT = 3'd7;

  localparam logic [6:0] PC_CODE_RESET = 7'd32;

  // One ROB entry as it sits in the memory.
  typedef struct packed {
    logic [1:0]  cls;
    logic [7:0]  tag;
    logic [5:0]  dreg;
    logic [31:0] value;
    logic [31:0] addr;
    logic [31:0] data;
    logic [31:0] pc;
    logic        rdy;
  } entry_t;
  localparam int ENTRY_W = $bits(entry_t);

  // One result item.
  typedef struct packed {
    logic        last;
    logic        flush;
    logic [31:0] data;
    logic [31:0] addr;
    logic [31:0] value;
    logic [5:0]  creg;
    logic [7:0]  ctag;
    logic [3:0]  slot;
    logic [2:0]  kind;
  } result_t;
endpackage
`default_nettype wire

// ----- src/rob_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rob_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rob_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]              rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ----- src/rob_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rob_ctrl
// Sequencer: walks the entry memory for updates, as read-modify-write, and
// for commits, one entry after another, and drives one result register.
// ----------------------------------------------------------------------------
module rob_ctrl (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic [5:0]               pc_code,
  input  wire logic                     req_valid,
  output logic                          req_ready,
  input  wire logic [1:0]               mode,
  input  wire logic [1:0]               op_class,
  input  wire logic [7:0]               tag,
  input  wire logic [31:0]              pc_value,
  input  wire logic [5:0]               dest_reg,
  input  wire logic [31:0]              result_value,
  input  wire logic [31:0]              store_address,
  input  wire logic [31:0]              store_value,
  input  wire logic                     ready_flag,
  input  wire logic                     is_store_update,
  output logic                          res_valid,
  input  wire logic                     res_ready,
  output rob_pkg::result_t              res,
  output logic                          mem_we,
  output logic [rob_pkg::SLOT_W-1:0]    mem_waddr,
  output rob_pkg::entry_t               mem_wdata,
  output logic [rob_pkg::SLOT_W-1:0]    mem_raddr,
  input  wire rob_pkg::entry_t          mem_rdata
);
  import rob_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_URD = 3'd1;   // update: read issued
  localparam logic [2:0] ST_UCHK = 3'd2;  // update: compare and write back
  localparam logic [2:0] ST_CRD = 3'd3;   // commit: read issued
  localparam logic [2:0] ST_CCHK = 3'd4;  // commit: examine oldest
  localparam logic [2:0] ST_OUT = 3'd5;   // hold commit until last is known

  logic [2:0]        state_r, state_nxt;
  logic [SLOT_W-1:0] oldest_r, oldest_nxt;
  logic [SLOT_W-1:0] next_r, next_nxt;
  logic [OCC_W-1:0]  occ_r, occ_nxt;
  logic              halted_r, halted_nxt;
  logic [OCC_W-1:0]  idx_r, idx_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              hit_r, hit_nxt;
  logic              rv_r, rv_nxt;
  result_t           res_r, res_nxt;
  // captured update request
  logic [7:0]        utag_r;
  logic [31:0]       uval_r, uaddr_r, udata_r;
  logic              urdy_r, ustore_r;

  logic              out_free;
  logic              hit_now, is_br, done;
  logic [SLOT_W-1:0] cur_slot;
  entry_t            upd;
  result_t           cres;

  assign out_free = !rv_r || res_ready;
  assign req_ready = (state_r == ST_IDLE) && !rv_r;
  assign res_valid = rv_r;
  assign res = res_r;

  function automatic logic [SLOT_W-1:0] wrap(input logic [SLOT_W-1:0] a,
                                              input logic [OCC_W-1:0] b);
    logic [OCC_W:0] s;
    s = {{(OCC_W + 1 - SLOT_W){1'b0}}, a} + {1'b0, b};
    if (s >= (OCC_W + 1)'(DEPTH)) begin
      s = s - (OCC_W + 1)'(DEPTH);
    end
    return s[SLOT_W-1:0];
  endfunction

  assign cur_slot = wrap(oldest_r, idx_r);
  assign hit_now = (mem_rdata.tag == utag_r);
  assign is_br = (mem_rdata.dreg == pc_code) && (mem_rdata.value == mem_rdata.pc + 32'd1);

  always_comb begin
    upd = mem_rdata;
    if (ustore_r) begin
      upd.addr = uaddr_r;
      upd.data = udata_r;
    end else begin
      upd.value = uval_r;
    end
    upd.rdy = urdy_r;
  end

  always_comb begin
    cres = '0;
    cres.ctag = mem_rdata.tag;
    cres.value = mem_rdata.value;
    cres.flush = is_br;
    if (mem_rdata.cls == CLASS_STORE) begin
      cres.kind = KIND_STORE;
      cres.addr = mem_rdata.addr;
      cres.data = mem_rdata.data;
    end else begin
      cres.kind = KIND_REG;
      cres.creg = mem_rdata.dreg;
    end
  end

  always_comb begin
    state_nxt = state_r;
    oldest_nxt = oldest_r;
    next_nxt = next_r;
    occ_nxt = occ_r;
    halted_nxt = halted_r;
    idx_nxt = idx_r;
    cnt_nxt = cnt_r;
    hit_nxt = hit_r;
    rv_nxt = rv_r && !res_ready;
    res_nxt = res_r;
    mem_we = 1'b0;
    mem_waddr = cur_slot;
    mem_wdata = upd;
    mem_raddr = cur_slot;
    done = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (req_valid && req_ready) begin
          unique case (mode)
            MODE_ALLOC: begin
              rv_nxt = 1'b1;
              res_nxt = '0;
              res_nxt.last = 1'b1;
              if (occ_r >= OCC_W'(DEPTH)) begin
                res_nxt.kind = KIND_FULL;
              end else begin
                res_nxt.kind = KIND_ALLOC;
                res_nxt.slot = 4'(next_r);
                mem_we = 1'b1;
                mem_waddr = next_r;
                mem_wdata = '{cls: op_class, tag: tag, dreg: dest_reg,
                              value: result_value, addr: store_address,
                              data: store_value, pc: pc_value, rdy: 1'b0};
                next_nxt = wrap(next_r, OCC_W'(1));
                occ_nxt = occ_r + OCC_W'(1);
              end
            end
            MODE_UPDATE: begin
              idx_nxt = '0;
              hit_nxt = 1'b0;
              if (occ_r == '0) begin
                rv_nxt = 1'b1;
                res_nxt = '0;
                res_nxt.kind = KIND_NOMATCH;
                res_nxt.last = 1'b1;
              end else begin
                state_nxt = ST_URD;
              end
            end
            MODE_TICK: begin
              idx_nxt = '0;
              cnt_nxt = '0;
              mem_raddr = oldest_r;
              if (halted_r || occ_r == '0) begin
                rv_nxt = 1'b1;
                res_nxt = '0;
                res_nxt.kind = KIND_NONE;
                res_nxt.last = 1'b1;
              end else begin
                state_nxt = ST_CCHK;
              end
            end
            default: ;
          endcase
        end
      end
      ST_URD: begin
        state_nxt = ST_UCHK;
      end
      ST_UCHK: begin
        if (hit_now) begin
          mem_we = 1'b1;
          hit_nxt = 1'b1;
        end
        // write-back to this slot comes before the read of the next slot in ST_URD
        if (idx_r + OCC_W'(1) >= occ_r) begin
          rv_nxt = 1'b1;
          res_nxt = '0;
          res_nxt.kind = (hit_r || hit_now) ? KIND_MATCH : KIND_NOMATCH;
          res_nxt.last = 1'b1;
          state_nxt = ST_IDLE;
        end else begin
          idx_nxt = idx_r + OCC_W'(1);
          state_nxt = ST_URD;
        end
      end
      ST_CRD: begin
        mem_raddr = oldest_r;
        state_nxt = ST_CCHK;
      end
      ST_CCHK: begin
        if (out_free) begin
          rv_nxt = 1'b1;
          res_nxt = '0;
          res_nxt.last = 1'b1;
          if (!mem_rdata.rdy) begin
            if (cnt_r == '0) begin
              res_nxt.kind = KIND_NONE;
            end else begin
              rv_nxt = 1'b0;
            end
            done = 1'b1;
          end else if (mem_rdata.cls == CLASS_HALT) begin
            halted_nxt = 1'b1;
            res_nxt.kind = KIND_HALT;
            res_nxt.ctag = mem_rdata.tag;
            done = 1'b1;
          end else begin
            res_nxt = cres;
            res_nxt.last = 1'b1;
            cnt_nxt = cnt_r + CNT_W'(1);
            if (is_br) begin
              oldest_nxt = next_r;
              occ_nxt = '0;
              done = 1'b1;
            end else begin
              oldest_nxt = wrap(oldest_r, OCC_W'(1));
              occ_nxt = occ_r - OCC_W'(1);
              if (occ_r == OCC_W'(1) || cnt_r + CNT_W'(1) == CNT_W'(MAX_RESULTS)) begin
                done = 1'b1;
              end else begin
                // last is unknown until the next entry is examined
                rv_nxt = 1'b0;
                state_nxt = ST_OUT;
                mem_raddr = wrap(oldest_r, OCC_W'(1));
              end
            end
          end
          if (done) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_OUT: begin
        // Hold the pending commit until the next entry tells whether it is last.
        mem_raddr = oldest_r;
        if (!mem_rdata.rdy || mem_rdata.cls == CLASS_HALT) begin
          rv_nxt = 1'b1;
          res_nxt.last = !mem_rdata.rdy;
          state_nxt = mem_rdata.rdy ? ST_CCHK : ST_IDLE;
          if (!mem_rdata.rdy) begin
            state_nxt = ST_IDLE;
          end
        end else begin
          rv_nxt = 1'b1;
          res_nxt.last = 1'b0;
          state_nxt = ST_CCHK;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // ST_OUT emits the held result; ST_CCHK must then wait until it drains.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      oldest_r <= '0;
      next_r <= '0;
      occ_r <= '0;
      halted_r <= 1'b0;
      rv_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      oldest_r <= oldest_nxt;
      next_r <= next_nxt;
      occ_r <= occ_nxt;
      halted_r <= halted_nxt;
      rv_r <= rv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    cnt_r <= cnt_nxt;
    hit_r <= hit_nxt;
    res_r <= res_nxt;
    if (req_valid && req_ready) begin
      utag_r <= tag;
      uval_r <= result_value;
      uaddr_r <= store_address;
      udata_r <= store_value;
      urdy_r <= ready_flag;
      ustore_r <= is_store_update;
    end
  end
endmodule
`default_nettype wire

// ----- src/reorder_buffer_commit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// reorder_buffer_commit
// Circular reorder buffer with in-order commit.
// ----------------------------------------------------------------------------
// Entries live in one RAM with a registered read. An allocate writes its entry,
// unless the buffer is full, and then waits on the output handshake. An update
// walks every occupied entry, reading it and then comparing and writing it back.
// A commit tick reads the oldest entry and gives one result per commit, each
// commit going through the RAM read port.
module reorder_buffer_commit (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [7:0]   cfg_data,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // mode
  input  wire logic [1:0]   in_tuser,
  // op_class, tag, pc_value, dest_reg, result_value, store_address,
  // store_value, ready_flag, is_store_update, zero pad
  input  wire logic [151:0] in_tdata,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // kind
  output logic [2:0]        out_tuser,
  // slot, commit_tag, commit_reg, commit_value, commit_address,
  // commit_data, flush, zero pad
  output logic [119:0]      out_tdata,
  output logic              out_tlast
);
  import rob_pkg::*;

  logic [5:0] pc_code_r;
  logic       mem_we;
  logic [SLOT_W-1:0] mem_waddr, mem_raddr;
  entry_t     mem_wdata, mem_rdata;
  result_t    res;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_code_r <= PC_CODE_RESET[5:0];
    end else if (cfg_valid) begin
      pc_code_r <= cfg_data[5:0];
    end
  end

  rob_ram #(.WIDTH(ENTRY_W), .DEPTH(DEPTH)) u_ram (
    .clk(clk), .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
    .raddr(mem_raddr), .rdata(mem_rdata)
  );

  rob_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .pc_code(pc_code_r),
    .req_valid(in_tvalid), .req_ready(in_tready),
    .mode(in_tuser), .op_class(in_tdata[1:0]), .tag(in_tdata[9:2]),
    .pc_value(in_tdata[41:10]), .dest_reg(in_tdata[47:42]),
    .result_value(in_tdata[79:48]), .store_address(in_tdata[111:80]),
    .store_value(in_tdata[143:112]), .ready_flag(in_tdata[144]),
    .is_store_update(in_tdata[145]),
    .res_valid(out_tvalid), .res_ready(out_tready), .res(res),
    .mem_we(mem_we), .mem_waddr(mem_waddr), .mem_wdata(mem_wdata),
    .mem_raddr(mem_raddr), .mem_rdata(mem_rdata)
  );

  assign out_tdata = {5'b0, res.flush, res.data, res.addr, res.value,
                      res.creg, res.ctag, res.slot};
  assign out_tuser = res.kind;
  assign out_tlast = res.last;
endmodule
`default_nettype wire

// ----- src/reorder_buffer_commit_chk.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// reorder_buffer_commit_chk
// Port-level checks for the reorder buffer.
// ----------------------------------------------------------------------------
`include "reorder_buffer_commit_macros.svh"
module reorder_buffer_commit_chk (
  input wire logic         clk,
  input wire logic         rst_n,
  input wire logic         in_tvalid,
  input wire logic         in_tready,
  input wire logic         out_tvalid,
  input wire logic         out_tready,
  input wire logic [2:0]   out_tuser,
  input wire logic [119:0] out_tdata,
  input wire logic         out_tlast
);
  import rob_pkg::*;

  logic [123:0] out_word;

  assign out_word = {out_tlast, out_tuser, out_tdata};

  `ROB_ASSERT(a_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_word), "result dropped")
  `ROB_ASSERT(a_no_take, out_tvalid |-> !in_tready, "request taken with result pending")
  `ROB_ASSERT(a_full_last, out_tvalid && out_tuser == KIND_FULL |-> out_tlast, "full not last")
  `ROB_ASSERT_ALWAYS(a_rst, !rst_n |=> !out_tvalid, "result after reset")
endmodule
bind reorder_buffer_commit reorder_buffer_commit_chk u_chk (.*);
`default_nettype wire
